// ----- rtl/scd_pkg.sv -----
// Shared constants, types and CRC function for the sync/CRC-8 pose frame deframer.
package scd_pkg;

    localparam logic [7:0] SYNC_RESET = 8'hA5;
    localparam logic [7:0] CRC_POLY   = 8'h8C;

    localparam int FRAME_LEN   = 1 + 4 * 4 + 1;
    localparam int PAYLOAD_LEN = FRAME_LEN - 2;
    localparam int POS_W       = 5;
    localparam int IDX_W       = 4;

    localparam int CMDQ_DEPTH_DEFAULT = 2;

    typedef enum logic [1:0] {
        CMD_SOF   = 2'b00,
        CMD_DATA  = 2'b01,
        CMD_CHECK = 2'b10
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } cmd_t;

    // reflected CRC-8/MAXIM, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       lsb;
        c = crc;
        d = data;
        for (int k = 0; k < 8; k++)
        begin
            lsb = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (lsb)
            begin
                c = c ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

// ----- rtl/scd_front.sv -----
// Front end: sync hunt, byte position tracking and command classification.
module scd_front
    import scd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] rx_byte,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       q_full,
    output logic       full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic [7:0]       sync_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_m1;
    logic             accept;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign pos_m1 = pos_reg - POS_W'(1);

    always_comb
    begin
        pos_next   = pos_reg;
        q_push     = 1'b0;
        q_cmd.kind = CMD_DATA;
        q_cmd.idx  = pos_m1[IDX_W-1:0];
        q_cmd.data = rx_byte;
        if (accept)
        begin
            if (pos_reg == '0)
            begin
                // hunting: only the sync byte opens a frame
                if (rx_byte == sync_reg)
                begin
                    pos_next   = POS_W'(1);
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_SOF;
                end
            end
            else if (pos_reg <= POS_W'(PAYLOAD_LEN))
            begin
                pos_next   = pos_reg + POS_W'(1);
                q_push     = 1'b1;
                q_cmd.kind = CMD_DATA;
            end
            else
            begin
                pos_next   = '0;
                q_push     = 1'b1;
                q_cmd.kind = CMD_CHECK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sync_reg <= SYNC_RESET;
        end
        else
        begin
            pos_reg <= pos_next;
            if (cfg_we)
            begin
                sync_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ----- rtl/scd_cmdq.sv -----
// Short command queue between front and back ends.
module scd_cmdq
    import scd_pkg::*;
#(
    parameter int DEPTH = CMDQ_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic q_empty,
    output logic q_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign q_empty = (cnt_reg == '0);
    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign rd_cmd  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

// ----- rtl/scd_back.sv -----
// Back end: CRC accumulation, payload assembly and the result register.
module scd_back
    import scd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] pos_z,
    output logic [31:0] std_dev
);

    logic [7:0]  crc_reg;
    logic [7:0]  crc_next;
    logic [31:0] word_reg [4];
    logic [31:0] res_x_reg;
    logic [31:0] res_y_reg;
    logic [31:0] res_z_reg;
    logic [31:0] res_sd_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic        slot_free;
    logic        wr_byte;
    logic        load_res;

    assign slot_free = !res_valid_reg || pop;
    assign q_pop     = !q_empty && ((q_cmd.kind != CMD_CHECK) || slot_free);

    assign empty   = !res_valid_reg;
    assign pos_x   = res_x_reg;
    assign pos_y   = res_y_reg;
    assign pos_z   = res_z_reg;
    assign std_dev = res_sd_reg;

    always_comb
    begin
        crc_next = crc_reg;
        wr_byte  = 1'b0;
        load_res = 1'b0;
        if (q_pop)
        begin
            unique case (q_cmd.kind)
                CMD_SOF:
                begin
                    crc_next = '0;
                end
                CMD_DATA:
                begin
                    crc_next = crc8_update(crc_reg, q_cmd.data);
                    wr_byte  = 1'b1;
                end
                CMD_CHECK:
                begin
                    load_res = (q_cmd.data == crc_reg);
                end
                default:
                begin
                    crc_next = crc_reg;
                end
            endcase
        end
        res_valid_next = (res_valid_reg && !pop) || load_res;
    end

    always_ff @(posedge clk)
    begin
        if (wr_byte)
        begin
            word_reg[q_cmd.idx[3:2]][{q_cmd.idx[1:0], 3'b000} +: 8] <= q_cmd.data;
        end
        if (load_res)
        begin
            res_x_reg  <= word_reg[0];
            res_y_reg  <= word_reg[1];
            res_z_reg  <= word_reg[2];
            res_sd_reg <= word_reg[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ----- rtl/sync_crc8_pose_frame_deframer.sv -----
// A result reaches the result ports through the command queue and then the result register
// when the result register is free; otherwise it waits until the held result is popped.
// Throughput: one byte per cycle while full is low; the front end and the back end each handle one byte a cycle.
// full rises only while a finished result waits to be popped and the command queue backs up.
// Reset (rst_n low, async): hunt for sync, CRC cleared, queue and result emptied,
// sync value back to 0xA5.
module sync_crc8_pose_frame_deframer
    import scd_pkg::*;
#(
    parameter int CMDQ_DEPTH = CMDQ_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // byte input, queue style
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    // sync value register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // pose result, queue style
    output logic        empty,
    input  logic        pop,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] pos_z,
    output logic [31:0] std_dev
);

    // Front: tracks the frame position and turns every byte transfer into
    // a command (start of frame, payload byte with its index, checksum).
    // Hunt bytes that are not the sync value make no command.
    logic q_push;
    cmd_t q_wr_cmd;
    logic q_full;

    scd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .full      (full),
        .q_push    (q_push),
        .q_cmd     (q_wr_cmd)
    );

    // Command queue: lets the front keep taking bytes while the back
    // holds a checksum command for a result slot that is still occupied.
    cmd_t q_rd_cmd;
    logic q_empty;
    logic q_pop;

    scd_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (q_wr_cmd),
        .rd_en   (q_pop),
        .rd_cmd  (q_rd_cmd),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    // Back: runs the CRC, assembles the little-endian words and loads the
    // result register on a checksum match. A mismatch drops the frame.
    scd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (q_rd_cmd),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .pos_x   (pos_x),
        .pos_y   (pos_y),
        .pos_z   (pos_z),
        .std_dev (std_dev)
    );

endmodule

// ----- rtl/scd_checker.sv -----
// Port-level assertions for the deframer, bound to the top level.
module scd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] pos_x,
    input logic [31:0] std_dev
);

    // queue backs up only behind a waiting result
    a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full while no result waits");

    // a new result follows an accepted byte transfer, through the command queue and result register
    a_result_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(push && !full, 2))
        else $error("result without a checksum byte transfer");

    // a result not popped holds its value
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pos_x) && $stable(std_dev)))
        else $error("waiting result changed or vanished");

    // out of reset no result waits and full is low
    a_reset_state: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("bad state after reset");

endmodule

bind sync_crc8_pose_frame_deframer scd_checker u_scd_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .pos_x   (pos_x),
    .std_dev (std_dev)
);

// ----- tb/pose_frame_checker.sv -----
// Pose frame checker: tracks sync, CRC and payload from the byte transfers and compares poses.
module pose_frame_checker
    import scd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] std_dev,
    output int          mismatch_count,
    output int          results_owed
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sd;
    } pose_t;

    logic [7:0]       sync_byte;
    logic [POS_W-1:0] frame_pos;     // 0 = hunting
    logic [7:0]       crc_acc;
    logic [31:0]      word_buf [4];
    pose_t            owed_poses [$];
    pose_t            next_pose;

    // reflected CRC-8, data folded in up front
    function automatic logic [7:0] crc8_maxim_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        logic [3:0] k;
        if (frame_pos == '0)
        begin
            if (b == sync_byte)
            begin
                frame_pos = POS_W'(1);
                crc_acc   = '0;
            end
        end
        else if (frame_pos <= POS_W'(PAYLOAD_LEN))
        begin
            k = 4'(frame_pos - 1'b1);
            word_buf[k[3:2]][{k[1:0], 3'b000} +: 8] = b;
            crc_acc   = crc8_maxim_step(crc_acc, b);
            frame_pos = frame_pos + 1'b1;
        end
        else
        begin
            frame_pos = '0;
            if (b == crc_acc)
            begin
                owed_poses.push_back({word_buf[0], word_buf[1], word_buf[2], word_buf[3]});
            end
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t %s: expected %08h, actual %08h", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte = SYNC_RESET;
            frame_pos = '0;
            crc_acc   = '0;
            owed_poses.delete();
            results_owed <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (owed_poses.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t pose: expected none, actual %08h %08h %08h %08h",
                             $time, pos_x, pos_y, pos_z, std_dev);
                end
                else
                begin
                    next_pose = owed_poses.pop_front();
                    check_field("pos_x", next_pose.x, pos_x);
                    check_field("pos_y", next_pose.y, pos_y);
                    check_field("pos_z", next_pose.z, pos_z);
                    check_field("std_dev", next_pose.sd, std_dev);
                end
            end
            if (cfg_we)
            begin
                sync_byte = cfg_wdata;
            end
            if (push && !full)
            begin
                deframe_byte(rx_byte);
            end
            results_owed <= owed_poses.size();
        end
    end

endmodule

// ----- tb/tb_sync_crc8_pose_frame_deframer.sv -----
// Testbench top for the pose frame deframer: byte and pose traffic, sync retuning, verdict.
module tb_sync_crc8_pose_frame_deframer;
    import scd_pkg::*;

    localparam int ITEM_TARGET   = 1550;
    // result passes the command queue and result register after the checksum transfer; give it margin
    localparam int SETTLE_CYCLES = 6;
    // longest correct quiet stretch is a settle pause plus a few gaps
    localparam int QUIET_LIMIT   = 2000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    logic [7:0]  rx_byte   = 8'h00;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        empty;
    logic        pop       = 1'b0;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] std_dev;

    int          mismatch_count;
    int          results_owed;
    int          quiet_cycles = 0;
    int          bytes_sent   = 0;

    // steady = no idle cycles on that side for the current phase
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    // sync value the block is believed to hold; frames are built with it
    logic [7:0]  sync_now = SYNC_RESET;
    logic [7:0]  frame_payload [16];

    always #5 clk = ~clk;

    sync_crc8_pose_frame_deframer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .empty     (empty),
        .pop       (pop),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .std_dev   (std_dev)
    );

    pose_frame_checker pose_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .empty          (empty),
        .pop            (pop),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .std_dev        (std_dev),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Watchdog: any transfer or register write counts as progress.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("sync_crc8_pose_frame_deframer verification failed");
            $finish;
        end
    end

    function automatic int pick_gap(input bit steady);
        return steady ? 0 : $urandom_range(0, 3);
    endfunction

    // One byte transfer. push stays high across back-to-back bytes, so it
    // is only dropped when a gap is drawn.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (full);
        bytes_sent++;
    endtask

    // Drain: every owed pose popped, then a settle pause so bytes that
    // produce nothing have left the command queue as well.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write only with the pipeline empty; the hunt/frame state
    // may still be mid-frame, which is intended.
    task automatic set_sync(input logic [7:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sync_now = v;
    endtask

    // Payload flavors: all zeros, all ones, sync bytes sprinkled in
    // (must not resync mid-frame), or plain random.
    task automatic fill_payload();
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < PAYLOAD_LEN; i++)
        begin
            case (mode)
                0:       frame_payload[i] = 8'h00;
                1:       frame_payload[i] = 8'hFF;
                2:       frame_payload[i] = ($urandom_range(0, 2) == 0) ? sync_now
                                                                       : 8'($urandom);
                default: frame_payload[i] = 8'($urandom);
            endcase
        end
    endtask

    // Sync, 16 payload bytes, checksum. retune_at in 0..16 writes a new
    // sync value after that many payload bytes (16 = just before the
    // checksum); the frame in flight must finish unaffected.
    task automatic send_frame(input bit bad_crc, input int retune_at,
                              input logic [7:0] retune_val);
        logic [7:0] crc;
        crc = 8'h00;
        send_byte(sync_now);
        for (int i = 0; i <= PAYLOAD_LEN; i++)
        begin
            if (i == retune_at)
            begin
                set_sync(retune_val);
            end
            if (i < PAYLOAD_LEN)
            begin
                send_byte(frame_payload[i]);
                crc = crc8_update(crc, frame_payload[i]);
            end
        end
        // bad checksum: flip one bit so the frame is dropped silently
        send_byte(bad_crc ? (crc ^ 8'(1 << $urandom_range(0, 7))) : crc);
    endtask

    // Result side: random pop stalls, held high while waiting for a pose.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = pick_gap(rx_steady);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        int         phase;
        int         roll;
        logic [7:0] next_sync;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extreme noise bytes while hunting, then a good frame at
        // the reset sync value whose payload mixes extremes and sync bytes.
        send_byte(8'h00);
        send_byte(8'hFF);
        frame_payload = '{8'h00, 8'hFF, SYNC_RESET, 8'h01, 8'h80, 8'h7F, 8'hFE, SYNC_RESET,
                          8'h00, 8'h00, 8'h80, 8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        send_frame(1'b0, -1, 8'h00);

        // Random phases. Each phase moves the sync value (cycling through
        // 0x00, 0xFF, random and the reset value), sometimes in the middle
        // of a frame, then sends mostly good frames with some bad
        // checksums, line noise and truncated frames.
        phase = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            phase++;
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            case (phase % 4)
                1:       next_sync = 8'hFF;
                2:       next_sync = 8'($urandom);
                3:       next_sync = SYNC_RESET;
                default: next_sync = 8'h00;
            endcase

            if (phase > 1 && $urandom_range(0, 2) == 0)
            begin
                fill_payload();
                send_frame(1'b0, $urandom_range(0, PAYLOAD_LEN), next_sync);
            end
            else
            begin
                set_sync(next_sync);
            end

            repeat ($urandom_range(5, 10))
            begin
                fill_payload();
                roll = $urandom_range(0, 19);
                if (roll < 14)
                begin
                    send_frame(1'b0, -1, 8'h00);
                end
                else if (roll < 16)
                begin
                    send_frame(1'b1, -1, 8'h00);
                end
                else if (roll < 18)
                begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
                else
                begin
                    // cut-off frame: the next frame's bytes get eaten as its tail
                    send_byte(sync_now);
                    repeat ($urandom_range(0, PAYLOAD_LEN - 1)) send_byte(8'($urandom));
                end
            end
        end

        settle();
        if (mismatch_count == 0)
        begin
            $display("sync_crc8_pose_frame_deframer verification clean");
        end
        else
        begin
            $display("sync_crc8_pose_frame_deframer verification failed");
        end
        $finish;
    end

endmodule
